// File: hdl/assert_macros.svh
// Assertion macros used by the scheduler checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on the clock with asynchronous reset disable.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Assert an implication that must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

// File: hdl/tsched_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task scheduler package
// Shared constants and codes of the task scheduler.
// ----------------------------------------------------------------------------
package tsched_pkg;
  localparam int unsigned Slots = 8;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CntW = $clog2(Slots + 1);

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam logic [1:0] ModeSjf = 2'd0;
  localparam logic [1:0] ModeRr = 2'd1;
  localparam logic [1:0] ModeSrtf = 2'd2;

  localparam logic [7:0] QuantReset = 8'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StZero = 2'd2;
  localparam logic [1:0] StIdle = 2'd3;

  localparam logic [1:0] RsnNone = 2'd0;
  localparam logic [1:0] RsnTerm = 2'd1;
  localparam logic [1:0] RsnPreempt = 2'd2;
  localparam logic [1:0] RsnQuantum = 2'd3;

  localparam logic RegMode = 1'b0;
  localparam logic RegQuantum = 1'b1;

  localparam logic OpAdmit = 1'b0;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] remaining;
    logic [15:0] burst;
    logic [15:0] arrival;
    slot_t       rank;
  } entry_t;
endpackage

// File: hdl/task_scheduler_sjf_rr_srtf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task scheduler (SJF / round robin / SRTF)
// Ready table in a synchronous memory, scanned slot by slot.
// ----------------------------------------------------------------------------
// Channel | direction | handshake
// in      | input     | in_valid_i / in_stall_o
// out     | output    | out_valid_o / out_stall_i
// cfg     | input     | cfg_valid_i / cfg_ready_o
// An admit passes straight to the result handoff before the next accept.
// A tick runs the selection scan with one memory read per slot, a planning step,
// a write back and the result handoff.
// When the running process ends or rotates, a second pass over the slots closes
// the queue gap before the write back.
// A stalled result holds the block; no item is taken meanwhile.
// Reset is asynchronous; valid bits live in flops, so the memory needs no clearing.
module task_scheduler_sjf_rr_srtf (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  process_id_i,
  input  logic [15:0] burst_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  running_id_o,
  output logic        dispatched_o,
  output logic [1:0]  switch_reason_o,
  output logic        finished_o,
  output logic [15:0] turnaround_time_o,
  output logic [15:0] waiting_time_o,
  output logic [15:0] current_time_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_PLAN  = 6'b000100,
    S_RANK  = 6'b001000,
    S_WRITE = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Slot memory: one write port and one registered read port.
  tsched_pkg::entry_t mem_q [tsched_pkg::Slots];
  tsched_pkg::entry_t rdata_q;
  logic               we;
  tsched_pkg::slot_t  waddr, raddr;
  tsched_pkg::entry_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  logic [tsched_pkg::Slots-1:0] valid_q;
  tsched_pkg::cnt_t   count_q;
  logic [15:0]        time_q;
  logic [7:0]         slice_q;
  tsched_pkg::slot_t  last_q;
  logic               alive_q;
  logic [1:0]         pend_q;
  logic [1:0]         mode_q;
  logic [7:0]         quant_q;

  // Scan registers.
  tsched_pkg::cnt_t   idx_q;
  logic               rd_q;
  tsched_pkg::slot_t  rdidx_q;
  logic               found_q;
  tsched_pkg::slot_t  best_q;
  tsched_pkg::entry_t bent_q;

  logic [1:0]  r_status_q, r_reason_q;
  logic [7:0]  r_id_q;
  logic        r_disp_q, r_fin_q;
  logic [15:0] r_tat_q, r_wt_q;
  logic        ov_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign status_o = r_status_q;
  assign running_id_o = r_id_q;
  assign dispatched_o = r_disp_q;
  assign switch_reason_o = r_reason_q;
  assign finished_o = r_fin_q;
  assign turnaround_time_o = r_tat_q;
  assign waiting_time_o = r_wt_q;
  assign current_time_o = time_q;

  logic              prev_live;
  logic              keep_last;
  logic              better;
  tsched_pkg::slot_t free_idx;
  logic              free_any;
  logic              admit_ok;
  logic              scan_end;
  logic [15:0]       rem_dec;
  logic [15:0]       tnext;
  logic [15:0]       run_tat;
  logic [7:0]        q_eff;
  logic [7:0]        slice_inc;
  logic [7:0]        slice_new;
  logic              run_fin;
  logic              run_disp;
  logic              run_rot;
  logic              need_rank;

  assign prev_live = alive_q && valid_q[last_q];
  assign keep_last = (mode_q == tsched_pkg::ModeSjf) && prev_live;
  assign admit_ok  = in_valid_i && (opcode_i == tsched_pkg::OpAdmit) &&
                     (burst_length_i != 16'd0) && free_any;
  assign scan_end  = (idx_q == tsched_pkg::cnt_t'(tsched_pkg::Slots));
  assign rem_dec   = bent_q.remaining - 16'd1;
  assign tnext     = time_q + 16'd1;
  assign run_tat   = tnext - bent_q.arrival;
  assign q_eff     = (quant_q == 8'd0) ? 8'd1 : quant_q;
  assign slice_inc = (slice_q == 8'hFF) ? slice_q : slice_q + 8'd1;

  // Plan for the selected slot once the scan is over.
  assign run_fin   = (rem_dec == 16'd0);
  assign run_disp  = !prev_live || (best_q != last_q);
  assign slice_new = run_disp ? 8'd1 : slice_inc;
  assign run_rot   = (mode_q == tsched_pkg::ModeRr) && !run_fin && (slice_new >= q_eff);
  assign need_rank = found_q && (run_fin || run_rot);

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = int'(tsched_pkg::Slots) - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = tsched_pkg::slot_t'(i);
        free_any = 1'b1;
      end
    end
  end

  // Compare the freshly read slot against the running best.
  always_comb begin
    if (keep_last) begin
      better = (rdidx_q == last_q);
    end else if (!found_q) begin
      better = 1'b1;
    end else if (mode_q == tsched_pkg::ModeRr) begin
      better = rdata_q.rank < bent_q.rank;
    end else begin
      better = (rdata_q.remaining < bent_q.remaining) ||
               ((rdata_q.remaining == bent_q.remaining) &&
                (rdata_q.rank < bent_q.rank));
    end
  end

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = rdidx_q;
    wdata = rdata_q;
    raddr = idx_q[tsched_pkg::SlotW-1:0];
    unique case (state_q)
      S_IDLE: begin
        waddr = free_idx;
        wdata.pid       = process_id_i;
        wdata.remaining = burst_length_i;
        wdata.burst     = burst_length_i;
        wdata.arrival   = time_q;
        wdata.rank      = tsched_pkg::slot_t'(count_q);
        we = admit_ok;
      end
      S_RANK: begin
        // Close the gap behind the removed or rotated slot.
        waddr = rdidx_q;
        wdata = rdata_q;
        wdata.rank = rdata_q.rank - tsched_pkg::slot_t'(1);
        we = rd_q && valid_q[rdidx_q] && (rdidx_q != best_q) &&
             (rdata_q.rank > bent_q.rank);
      end
      S_WRITE: begin
        waddr = best_q;
        wdata = bent_q;
        wdata.remaining = rem_dec;
        wdata.rank = run_rot ? tsched_pkg::slot_t'(count_q - tsched_pkg::cnt_t'(1))
                             : bent_q.rank;
        we = found_q && !run_fin;
      end
      default: begin
      end
    endcase
  end

  // Table state, scan registers and result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      count_q    <= '0;
      time_q     <= '0;
      slice_q    <= '0;
      last_q     <= '0;
      alive_q    <= 1'b0;
      pend_q     <= tsched_pkg::RsnNone;
      mode_q     <= tsched_pkg::ModeSrtf;
      quant_q    <= tsched_pkg::QuantReset;
      ov_q       <= 1'b0;
      idx_q      <= '0;
      rd_q       <= 1'b0;
      rdidx_q    <= '0;
      found_q    <= 1'b0;
      best_q     <= '0;
      bent_q     <= '0;
      r_status_q <= tsched_pkg::StOk;
      r_reason_q <= tsched_pkg::RsnNone;
      r_id_q     <= '0;
      r_disp_q   <= 1'b0;
      r_fin_q    <= 1'b0;
      r_tat_q    <= '0;
      r_wt_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == tsched_pkg::RegMode) begin
              mode_q <= cfg_data_i[1:0];
            end else begin
              quant_q <= cfg_data_i;
            end
          end
          if (in_valid_i) begin
            idx_q   <= '0;
            rd_q    <= 1'b0;
            found_q <= 1'b0;
            // An admit completes right away.
            if (opcode_i == tsched_pkg::OpAdmit) begin
              ov_q       <= 1'b1;
              r_id_q     <= '0;
              r_disp_q   <= 1'b0;
              r_reason_q <= tsched_pkg::RsnNone;
              r_fin_q    <= 1'b0;
              r_tat_q    <= '0;
              r_wt_q     <= '0;
              if (burst_length_i == 16'd0) begin
                r_status_q <= tsched_pkg::StZero;
              end else if (!free_any) begin
                r_status_q <= tsched_pkg::StFull;
              end else begin
                r_status_q <= tsched_pkg::StOk;
                valid_q[free_idx] <= 1'b1;
                count_q <= count_q + tsched_pkg::cnt_t'(1);
              end
            end
          end
        end
        S_SCAN: begin
          // One slot read per cycle; compare the previous read.
          rd_q    <= !scan_end;
          rdidx_q <= idx_q[tsched_pkg::SlotW-1:0];
          if (!scan_end) begin
            idx_q <= idx_q + tsched_pkg::cnt_t'(1);
          end
          if (rd_q && valid_q[rdidx_q] && better) begin
            found_q <= 1'b1;
            best_q  <= rdidx_q;
            bent_q  <= rdata_q;
          end
        end
        S_PLAN: begin
          idx_q <= '0;
          rd_q  <= 1'b0;
        end
        S_RANK: begin
          rd_q    <= !scan_end;
          rdidx_q <= idx_q[tsched_pkg::SlotW-1:0];
          if (!scan_end) begin
            idx_q <= idx_q + tsched_pkg::cnt_t'(1);
          end
        end
        S_WRITE: begin
          ov_q       <= 1'b1;
          time_q     <= tnext;
          r_id_q     <= '0;
          r_disp_q   <= 1'b0;
          r_reason_q <= tsched_pkg::RsnNone;
          r_fin_q    <= 1'b0;
          r_tat_q    <= '0;
          r_wt_q     <= '0;
          if (!found_q) begin
            // Idle tick: nothing ran, the pending reason is kept.
            r_status_q <= tsched_pkg::StIdle;
            alive_q    <= 1'b0;
            slice_q    <= '0;
          end else begin
            r_status_q <= tsched_pkg::StOk;
            r_id_q     <= bent_q.pid;
            last_q     <= best_q;
            if (run_disp) begin
              r_disp_q <= 1'b1;
              if (prev_live) begin
                r_reason_q <= (pend_q == tsched_pkg::RsnQuantum) ?
                              tsched_pkg::RsnQuantum : tsched_pkg::RsnPreempt;
              end else begin
                r_reason_q <= pend_q;
              end
            end
            if (run_fin) begin
              r_fin_q <= 1'b1;
              r_tat_q <= run_tat;
              r_wt_q  <= run_tat - bent_q.burst;
              valid_q[best_q] <= 1'b0;
              count_q <= count_q - tsched_pkg::cnt_t'(1);
              alive_q <= 1'b0;
              slice_q <= '0;
              pend_q  <= tsched_pkg::RsnTerm;
            end else begin
              alive_q <= 1'b1;
              if (run_rot) begin
                slice_q <= '0;
                pend_q  <= tsched_pkg::RsnQuantum;
              end else begin
                pend_q  <= tsched_pkg::RsnNone;
                slice_q <= (mode_q == tsched_pkg::ModeRr) ? slice_new : 8'd0;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            ov_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (opcode_i == tsched_pkg::OpAdmit) ? S_OUT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) state_d = S_PLAN;
      end
      S_PLAN: begin
        state_d = need_rank ? S_RANK : S_WRITE;
      end
      S_RANK: begin
        if (scan_end) state_d = S_WRITE;
      end
      S_WRITE: state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// File: hdl/tsched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task scheduler checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tsched_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic        dispatched_o,
  input logic [1:0]  switch_reason_o,
  input logic        finished_o,
  input logic [15:0] turnaround_time_o
);
  logic reason_clear;
  logic tat_clear;
  logic idle_out;
  logic idle_quiet;

  assign reason_clear = (switch_reason_o == tsched_pkg::RsnNone);
  assign tat_clear    = (turnaround_time_o == 16'd0);
  assign idle_out     = out_valid_o && (status_o == tsched_pkg::StIdle);
  assign idle_quiet   = !dispatched_o && !finished_o;

  // A result that is not dispatched carries no reason.
  `ASSERT_IMPL(a_reason, clk_i, rst_ni, out_valid_o && !dispatched_o, reason_clear, "stray reason")
  // Only a finished item reports a turnaround time.
  `ASSERT_IMPL(a_tat, clk_i, rst_ni, out_valid_o && !finished_o, tat_clear, "stray turnaround")
  // An idle tick runs nothing.
  `ASSERT_IMPL(a_idle, clk_i, rst_ni, idle_out, idle_quiet, "idle tick ran")
  // A stalled result stays.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  // An accepted item keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "not busy")
endmodule

bind task_scheduler_sjf_rr_srtf tsched_checker u_tsched_checker (.*);
